@@ sv/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes for the indexed list engine: request operations,
// result status codes and the sequencer states.
// ----------------------------------------------------------------------------
package ile_pkg;

    // Request operation codes (input tuser)
    typedef enum logic [3:0] {
        OP_ADD_FRONT = 4'd0,
        OP_ADD_BACK  = 4'd1,
        OP_INSERT_AT = 4'd2,
        OP_POP_FRONT = 4'd3,
        OP_POP_BACK  = 4'd4,
        OP_POP_AT    = 4'd5,
        OP_READ_AT   = 4'd6,
        OP_FIND      = 4'd7,
        OP_CLEAR     = 4'd8,
        OP_REVERSE   = 4'd9
    } t_op;

    // Result status codes (output tuser)
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REM_HEAD,
        S_REM_SHIFT,
        S_READ,
        S_FIND,
        S_REV_RDHI,
        S_REV_WRLO,
        S_REV_WRHI,
        S_DONE
    } t_state;

    // Stream field widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

endpackage

@@ sv/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of up to DEPTH values held in a synchronous memory
// with one write and one read port, with insert, remove, read, find, clear
// and reverse.
// ----------------------------------------------------------------------------
// The list lives in one memory with one write and one registered read per
// cycle, so every request walks the stored entries one at a time: inserting
// or removing at position p walks the entries from p to the end, find walks
// from the front until a match or the end, and reverse swaps entries in pairs
// from both ends. A request is taken only while the sequencer is idle; each
// request returns exactly one result, held in an output register until
// the downstream side takes it. No clearing pass is needed after reset:
// entries at or past the count are never read.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] item_index, [39:8] item_value
    input  logic [ile_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [3:0] operation
    input  logic [ile_pkg::IN_TUSER_W-1:0]   i_s_tuser,
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] read_value, [37:32] found_position, [44:38] element_count,
    // [47:45] zero
    output logic [ile_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // [1:0] status
    output logic [ile_pkg::OUT_TUSER_W-1:0]  o_m_tuser
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ile_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_hi, n_hi;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [DATA_WIDTH-1:0] r_hold, n_hold;
    logic [31:0]        r_rv, n_rv;
    logic [5:0]         r_fpos, n_fpos;
    ile_pkg::t_status   r_st, n_st;

    logic               r_out_valid;
    logic [31:0]        r_out_rv;
    logic [5:0]         r_out_fpos;
    logic [6:0]         r_out_cnt;
    ile_pkg::t_status   r_out_st;

    // memory and its ports
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic                  mem_re, mem_we;
    logic [AW-1:0]         mem_ra, mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;

    // ------------------------------------------------------------------
    // Request decode and walk conditions
    // ------------------------------------------------------------------
    ile_pkg::t_op       req_op;
    logic [7:0]         req_idx;
    logic [31:0]        req_val;
    logic [63:0]        req_val64;
    logic [CMPW-1:0]    idx_u, cnt_u;
    logic               idx_neg, idx_ok, ins_full, cnt_zero;
    logic [AW-1:0]      ins_pos;
    logic               accept, out_free, ptr_more, rev_more, hit;
    logic [63:0]        rd_sext;

    assign req_op    = ile_pkg::t_op'(i_s_tuser);
    assign req_idx   = i_s_tdata[7:0];
    assign req_val   = i_s_tdata[39:8];
    assign req_val64 = {{32{req_val[31]}}, req_val};
    assign idx_neg   = req_idx[7];
    assign idx_u     = CMPW'(req_idx[6:0]);
    assign cnt_u     = CMPW'(r_count);
    assign idx_ok    = !idx_neg && (idx_u < cnt_u);
    assign ins_full  = (r_count == FULL_CNT);
    assign cnt_zero  = (r_count == '0);

    // clamp insert position to [0, count]
    always_comb begin
        if (idx_neg) begin
            ins_pos = '0;
        end else if (idx_u >= cnt_u) begin
            ins_pos = AW'(r_count);
        end else begin
            ins_pos = AW'(idx_u);
        end
    end

    assign o_s_tready = (r_state == ile_pkg::S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign ptr_more   = ((CW'(r_ptr) + CW'(1)) < r_count);
    assign rev_more   = ((CW'(r_ptr) + CW'(2)) < CW'(r_hi));
    assign hit        = (r_rdata == r_val);
    assign rd_sext    = 64'($signed(r_rdata));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ile_pkg::S_IDLE: begin
                if (accept) begin
                    case (req_op)
                        ile_pkg::OP_ADD_FRONT, ile_pkg::OP_ADD_BACK,
                        ile_pkg::OP_INSERT_AT: begin
                            if (ins_full) begin
                                n_state = ile_pkg::S_DONE;
                            end else if ((req_op == ile_pkg::OP_ADD_BACK) || cnt_zero ||
                                         ((req_op == ile_pkg::OP_INSERT_AT) &&
                                          (CW'(ins_pos) == r_count))) begin
                                n_state = ile_pkg::S_INS_PUT;
                            end else begin
                                n_state = ile_pkg::S_INS_SHIFT;
                            end
                        end
                        ile_pkg::OP_POP_FRONT, ile_pkg::OP_POP_BACK: begin
                            n_state = cnt_zero ? ile_pkg::S_DONE : ile_pkg::S_REM_HEAD;
                        end
                        ile_pkg::OP_POP_AT: begin
                            n_state = idx_ok ? ile_pkg::S_REM_HEAD : ile_pkg::S_DONE;
                        end
                        ile_pkg::OP_READ_AT: begin
                            n_state = idx_ok ? ile_pkg::S_READ : ile_pkg::S_DONE;
                        end
                        ile_pkg::OP_FIND: begin
                            n_state = cnt_zero ? ile_pkg::S_DONE : ile_pkg::S_FIND;
                        end
                        ile_pkg::OP_REVERSE: begin
                            n_state = (r_count < CW'(2)) ? ile_pkg::S_DONE
                                                         : ile_pkg::S_REV_RDHI;
                        end
                        default: begin
                            n_state = ile_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ile_pkg::S_INS_SHIFT: begin
                if (r_ptr == r_pos) begin
                    n_state = ile_pkg::S_INS_PUT;
                end
            end
            ile_pkg::S_INS_PUT:   n_state = ile_pkg::S_DONE;
            ile_pkg::S_REM_HEAD,
            ile_pkg::S_REM_SHIFT: begin
                n_state = ptr_more ? ile_pkg::S_REM_SHIFT : ile_pkg::S_DONE;
            end
            ile_pkg::S_READ:      n_state = ile_pkg::S_DONE;
            ile_pkg::S_FIND: begin
                if (hit || !ptr_more) begin
                    n_state = ile_pkg::S_DONE;
                end
            end
            ile_pkg::S_REV_RDHI:  n_state = ile_pkg::S_REV_WRLO;
            ile_pkg::S_REV_WRLO:  n_state = ile_pkg::S_REV_WRHI;
            ile_pkg::S_REV_WRHI: begin
                n_state = rev_more ? ile_pkg::S_REV_RDHI : ile_pkg::S_DONE;
            end
            ile_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            default:              n_state = ile_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb begin
        n_count = r_count;
        n_ptr   = r_ptr;
        n_pos   = r_pos;
        n_hi    = r_hi;
        n_val   = r_val;
        n_hold  = r_hold;
        n_rv    = r_rv;
        n_fpos  = r_fpos;
        n_st    = r_st;
        mem_re  = 1'b0;
        mem_ra  = r_ptr;
        mem_we  = 1'b0;
        mem_wa  = r_ptr;
        mem_wd  = r_rdata;
        case (r_state)
            ile_pkg::S_IDLE: begin
                if (accept) begin
                    // latch request, default to an ok result with zero fields
                    n_val  = req_val64[DATA_WIDTH-1:0];
                    n_rv   = '0;
                    n_fpos = '0;
                    n_st   = ile_pkg::ST_OK;
                    case (req_op)
                        ile_pkg::OP_ADD_FRONT, ile_pkg::OP_ADD_BACK,
                        ile_pkg::OP_INSERT_AT: begin
                            if (ins_full) begin
                                n_st = ile_pkg::ST_FULL;
                            end else begin
                                if (req_op == ile_pkg::OP_ADD_FRONT) begin
                                    n_pos = '0;
                                end else if (req_op == ile_pkg::OP_ADD_BACK) begin
                                    n_pos = AW'(r_count);
                                end else begin
                                    n_pos = ins_pos;
                                end
                                // start the shift from the last element
                                n_ptr  = AW'(r_count - CW'(1));
                                mem_re = !cnt_zero;
                                mem_ra = AW'(r_count - CW'(1));
                            end
                        end
                        ile_pkg::OP_POP_FRONT, ile_pkg::OP_POP_BACK,
                        ile_pkg::OP_POP_AT, ile_pkg::OP_READ_AT: begin
                            if (req_op == ile_pkg::OP_POP_FRONT) begin
                                n_ptr = '0;
                            end else if (req_op == ile_pkg::OP_POP_BACK) begin
                                n_ptr = AW'(r_count - CW'(1));
                            end else begin
                                n_ptr = AW'(idx_u);
                            end
                            mem_ra = n_ptr;
                            if (((req_op == ile_pkg::OP_POP_FRONT) ||
                                 (req_op == ile_pkg::OP_POP_BACK)) ? cnt_zero : !idx_ok) begin
                                n_st = ile_pkg::ST_MISS;
                            end else begin
                                mem_re = 1'b1;
                            end
                        end
                        ile_pkg::OP_FIND: begin
                            n_ptr  = '0;
                            mem_ra = '0;
                            if (cnt_zero) begin
                                n_st = ile_pkg::ST_MISS;
                            end else begin
                                mem_re = 1'b1;
                            end
                        end
                        ile_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        ile_pkg::OP_REVERSE: begin
                            // low end walks in r_ptr, high end in r_hi
                            n_ptr  = '0;
                            n_hi   = AW'(r_count - CW'(1));
                            mem_ra = '0;
                            mem_re = (r_count >= CW'(2));
                        end
                        default: begin
                            n_st = ile_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            ile_pkg::S_INS_SHIFT: begin
                // move one element up, fetch the one below it
                mem_we = 1'b1;
                mem_wa = r_ptr + AW'(1);
                mem_wd = r_rdata;
                if (r_ptr != r_pos) begin
                    n_ptr  = r_ptr - AW'(1);
                    mem_re = 1'b1;
                    mem_ra = r_ptr - AW'(1);
                end
            end
            ile_pkg::S_INS_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos;
                mem_wd  = r_val;
                n_count = r_count + CW'(1);
            end
            ile_pkg::S_REM_HEAD, ile_pkg::S_REM_SHIFT: begin
                if (r_state == ile_pkg::S_REM_HEAD) begin
                    n_rv = rd_sext[31:0];
                end else begin
                    // move one element down
                    mem_we = 1'b1;
                    mem_wa = r_ptr - AW'(1);
                    mem_wd = r_rdata;
                end
                if (ptr_more) begin
                    n_ptr  = r_ptr + AW'(1);
                    mem_re = 1'b1;
                    mem_ra = r_ptr + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            ile_pkg::S_READ: begin
                n_rv = rd_sext[31:0];
            end
            ile_pkg::S_FIND: begin
                if (hit) begin
                    n_fpos = 6'(r_ptr);
                end else if (ptr_more) begin
                    n_ptr  = r_ptr + AW'(1);
                    mem_re = 1'b1;
                    mem_ra = r_ptr + AW'(1);
                end else begin
                    n_st = ile_pkg::ST_MISS;
                end
            end
            ile_pkg::S_REV_RDHI: begin
                // low element arrives, fetch the high one
                n_hold = r_rdata;
                mem_re = 1'b1;
                mem_ra = r_hi;
            end
            ile_pkg::S_REV_WRLO: begin
                mem_we = 1'b1;
                mem_wa = r_ptr;
                mem_wd = r_rdata;
            end
            ile_pkg::S_REV_WRHI: begin
                mem_we = 1'b1;
                mem_wa = r_hi;
                mem_wd = r_hold;
                if (rev_more) begin
                    n_ptr  = r_ptr + AW'(1);
                    n_hi   = r_hi - AW'(1);
                    mem_re = 1'b1;
                    mem_ra = r_ptr + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Element memory: one write, one registered read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ile_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_pos  <= n_pos;
        r_hi   <= n_hi;
        r_val  <= n_val;
        r_hold <= n_hold;
        r_rv   <= n_rv;
        r_fpos <= n_fpos;
        r_st   <= n_st;
    end

    // ------------------------------------------------------------------
    // Output register: load the finished result, drop it on transfer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ile_pkg::S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ile_pkg::S_DONE) && out_free) begin
            r_out_rv   <= r_rv;
            r_out_fpos <= r_fpos;
            r_out_cnt  <= 7'(r_count);
            r_out_st   <= r_st;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_cnt, r_out_fpos, r_out_rv};
    assign o_m_tuser  = r_out_st;

endmodule
